// ----- sv/srsw_pkg.sv -----
// Shared constants, types and helpers for the selective repeat sender window.
package srsw_pkg;

  // Configurable sizes
  localparam int MAX_WINDOW        = 8;
  localparam int FRAME_NUMBER_BITS = 16;
  localparam int RESULT_CAP        = 8;

  // Derived widths
  localparam int CELLS  = (MAX_WINDOW < RESULT_CAP) ? MAX_WINDOW : RESULT_CAP;
  localparam int OFF_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int NUM_W  = FRAME_NUMBER_BITS + 1;
  localparam int WS_W   = 4;
  localparam int TF_W   = FRAME_NUMBER_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TF_W;

  localparam logic [WS_W-1:0] WIN_LIMIT = WS_W'(CELLS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = CFG_IDX_W'(1);

  // Reset values of the registers
  localparam logic [WS_W-1:0] WINDOW_SIZE_RST = WS_W'(3);
  localparam logic [TF_W-1:0] FRAME_LIMIT_RST = TF_W'(6);

  // Event codes
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } opcode_t;

  // Control from the sequencer to the row of cells
  typedef struct packed {
    logic             shift;
    logic             set_en;
    logic [OFF_W-1:0] set_off;
  } chain_ctl_t;

  // Index of the lowest set bit, zero when none is set
  function automatic logic [OFF_W-1:0] lowest_set(input logic [CELLS-1:0] v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = CELLS - 1; i >= 0; i--) begin
      if (v[i]) idx = OFF_W'(i);
    end
    return idx;
  endfunction

  // Whether any bit above position sel is set
  function automatic logic any_above(input logic [CELLS-1:0] v,
                                     input logic [OFF_W-1:0] sel);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < CELLS; i++) begin
      if ((OFF_W'(i) > sel) && v[i]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ----- sv/srsw_cell.sv -----
// One window slot: acknowledged mark for the frame at its offset from the base.
module srsw_cell (
  input  logic clk,
  input  logic rst_n,
  input  logic shift_i,
  input  logic set_i,
  input  logic nbr_i,
  output logic mark_o
);

  logic mark_r;
  logic mark_nxt;

  // Take the neighbor's mark on a slide, else set on an ack
  always_comb begin
    if (shift_i) begin
      mark_nxt = nbr_i;
    end else begin
      mark_nxt = mark_r | set_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= 1'b0;
    end else begin
      mark_r <= mark_nxt;
    end
  end

  assign mark_o = mark_r;

endmodule

// ----- sv/srsw_chain.sv -----
// Row of window cells; slot zero holds the frame at the window base.
module srsw_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  srsw_pkg::chain_ctl_t      ctl,
  output logic [srsw_pkg::CELLS-1:0] marks
);

  for (genvar i = 0; i < srsw_pkg::CELLS; i++) begin : g_cell
    logic nbr;
    logic set;

    // Top cell shifts in a cleared mark
    if (i == srsw_pkg::CELLS - 1) begin : g_top
      assign nbr = 1'b0;
    end else begin : g_mid
      assign nbr = marks[i+1];
    end

    assign set = ctl.set_en && (ctl.set_off == srsw_pkg::OFF_W'(i));

    srsw_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_i (ctl.shift),
      .set_i   (set),
      .nbr_i   (nbr),
      .mark_o  (marks[i])
    );
  end

endmodule

// ----- sv/selective_repeat_sender_window.sv -----
// Top level of the selective repeat ARQ sender window.
//
// Each accepted event beat is worked off by a sequencer that emits one result
// per cycle into an output register while the output is not stalled; the next
// event is taken in the cycle after its last result is loaded. A start then sends
// one result per new frame (an empty result if there is none). A timeout then
// sends one result per resent frame (at least one). An ack uses its accept to
// mark its slot, slides the base past the acknowledged frames through the row of
// cells (one slot per cycle), then sends one result per new frame, at least one.
module selective_repeat_sender_window (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // event channel
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [1:0]                                in_opcode,
  input  logic [srsw_pkg::FRAME_NUMBER_BITS-1:0]    in_ack_number,
  // result channel
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic                                      out_frame_valid,
  output logic [srsw_pkg::FRAME_NUMBER_BITS-1:0]    out_frame_number,
  output logic                                      out_is_resend,
  output logic                                      out_last,
  output logic                                      out_all_done,
  // configuration channel
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]           cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SLIDE = 6'b000010,
    ST_FILL  = 6'b000100,
    ST_TOUT  = 6'b001000,
    ST_EMPTY = 6'b010000,
    ST_SPARE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [srsw_pkg::NUM_W-1:0] base_r, base_nxt;
  logic [srsw_pkg::NUM_W-1:0] next_r, next_nxt;
  logic [srsw_pkg::CNT_W-1:0] cursor_r, cursor_nxt;
  logic [srsw_pkg::WS_W-1:0]  window_size_r;
  logic [srsw_pkg::TF_W-1:0]  frame_limit_r;

  logic                                   out_valid_r, out_valid_nxt;
  logic                                   frame_valid_r, frame_valid_nxt;
  logic [srsw_pkg::FRAME_NUMBER_BITS-1:0] frame_number_r, frame_number_nxt;
  logic                                   is_resend_r, is_resend_nxt;
  logic                                   last_r, last_nxt;
  logic                                   all_done_r, all_done_nxt;
  logic                                   load;

  srsw_pkg::chain_ctl_t       ctl;
  logic [srsw_pkg::CELLS-1:0] marks;

  logic                       in_fire;
  logic                       out_free;
  logic [srsw_pkg::NUM_W-1:0] span;
  logic [srsw_pkg::CNT_W-1:0] count;
  logic [srsw_pkg::WS_W-1:0]  eff_w_full;
  logic [srsw_pkg::CNT_W-1:0] eff_w;
  logic [srsw_pkg::NUM_W-1:0] total_ext;
  logic                       fill_ok;
  logic                       fill_more;
  logic [srsw_pkg::NUM_W-1:0] ack_ext;
  logic                       ack_in_win;
  logic [srsw_pkg::NUM_W-1:0] ack_off;
  logic [srsw_pkg::CELLS-1:0] pending;
  logic [srsw_pkg::OFF_W-1:0] sel;
  logic                       any_pending;
  logic                       more_pending;
  logic [srsw_pkg::NUM_W-1:0] resend_num;

  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Window occupancy and effective window
  assign span      = next_r - base_r;
  assign count     = span[srsw_pkg::CNT_W-1:0];
  assign total_ext = {1'b0, frame_limit_r};

  always_comb begin
    if (window_size_r == '0) begin
      eff_w_full = srsw_pkg::WS_W'(1);
    end else if (window_size_r > srsw_pkg::WIN_LIMIT) begin
      eff_w_full = srsw_pkg::WIN_LIMIT;
    end else begin
      eff_w_full = window_size_r;
    end
  end
  assign eff_w = eff_w_full[srsw_pkg::CNT_W-1:0];

  assign fill_ok   = (count < eff_w) && (next_r <= total_ext);
  assign fill_more = (srsw_pkg::CNT_W'(count + 1'b1) < eff_w) && (next_r < total_ext);

  // Ack range check and slot offset
  assign ack_ext    = {1'b0, in_ack_number};
  assign ack_in_win = (ack_ext >= base_r) && (ack_ext < next_r);
  assign ack_off    = ack_ext - base_r;

  // Unacknowledged slots at or past the scan cursor
  always_comb begin
    for (int i = 0; i < srsw_pkg::CELLS; i++) begin
      pending[i] = (srsw_pkg::CNT_W'(i) < count) && !marks[i] &&
                   (srsw_pkg::CNT_W'(i) >= cursor_r);
    end
  end
  assign sel          = srsw_pkg::lowest_set(pending);
  assign any_pending  = |pending;
  assign more_pending = srsw_pkg::any_above(pending, sel);
  assign resend_num   = base_r + srsw_pkg::NUM_W'(sel);

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    base_nxt         = base_r;
    next_nxt         = next_r;
    cursor_nxt       = cursor_r;
    ctl.shift        = 1'b0;
    ctl.set_en       = 1'b0;
    ctl.set_off      = ack_off[srsw_pkg::OFF_W-1:0];
    load             = 1'b0;
    frame_valid_nxt  = 1'b0;
    frame_number_nxt = '0;
    is_resend_nxt    = 1'b0;
    last_nxt         = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cursor_nxt = '0;
          unique case (srsw_pkg::opcode_t'(in_opcode))
            srsw_pkg::OP_START: state_nxt = ST_FILL;
            srsw_pkg::OP_ACK: begin
              ctl.set_en = ack_in_win;
              state_nxt  = ST_SLIDE;
            end
            srsw_pkg::OP_TIMEOUT: state_nxt = ST_TOUT;
            default: state_nxt = ST_EMPTY;
          endcase
        end
      end
      ST_SLIDE: begin
        // Drop acknowledged frames from the bottom of the window
        if ((count != '0) && marks[0]) begin
          ctl.shift = 1'b1;
          base_nxt  = base_r + 1'b1;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (out_free) begin
          load = 1'b1;
          if (fill_ok) begin
            frame_valid_nxt  = 1'b1;
            frame_number_nxt = next_r[srsw_pkg::FRAME_NUMBER_BITS-1:0];
            last_nxt         = !fill_more;
            next_nxt         = next_r + 1'b1;
            if (!fill_more) state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TOUT: begin
        if (out_free) begin
          load = 1'b1;
          if (any_pending) begin
            frame_valid_nxt  = 1'b1;
            frame_number_nxt = resend_num[srsw_pkg::FRAME_NUMBER_BITS-1:0];
            is_resend_nxt    = 1'b1;
            last_nxt         = !more_pending;
            cursor_nxt       = srsw_pkg::CNT_W'(sel) + 1'b1;
            if (!more_pending) state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign all_done_nxt = (base_r > total_ext);

  // Output register handshake
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      base_r        <= srsw_pkg::NUM_W'(1);
      next_r        <= srsw_pkg::NUM_W'(1);
      cursor_r      <= '0;
      out_valid_r   <= 1'b0;
      window_size_r <= srsw_pkg::WINDOW_SIZE_RST;
      frame_limit_r <= srsw_pkg::FRAME_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      // Register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          srsw_pkg::CFG_WINDOW_SIZE: window_size_r <= cfg_data[srsw_pkg::WS_W-1:0];
          srsw_pkg::CFG_FRAME_LIMIT: frame_limit_r <= cfg_data[srsw_pkg::TF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result payload, held while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      frame_valid_r  <= frame_valid_nxt;
      frame_number_r <= frame_number_nxt;
      is_resend_r    <= is_resend_nxt;
      last_r         <= last_nxt;
      all_done_r     <= all_done_nxt;
    end
  end

  srsw_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .marks (marks)
  );

  assign out_valid        = out_valid_r;
  assign out_frame_valid  = frame_valid_r;
  assign out_frame_number = frame_number_r;
  assign out_is_resend    = is_resend_r;
  assign out_last         = last_r;
  assign out_all_done     = all_done_r;

endmodule

// ----- sv/srsw_checker.sv -----
// Port-level checks for the sender window, bound to the top level.
module srsw_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic                                   out_frame_valid,
  input logic [srsw_pkg::FRAME_NUMBER_BITS-1:0] out_frame_number,
  input logic                                   out_is_resend,
  input logic                                   out_last,
  input logic                                   out_all_done
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_number) &&
                               $stable(out_last) && $stable(out_frame_valid) &&
                               $stable(out_is_resend) && $stable(out_all_done))
    else $error("stalled result beat changed");

  // An accepted event blocks the next one until its results are out
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("event taken while previous one still in progress");

  // An empty result is a bare final beat
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_valid |->
      out_last && (out_frame_number == '0) && !out_is_resend)
    else $error("malformed empty result");

  // Frames are numbered from one
  a_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_valid |-> out_frame_number != '0)
    else $error("frame number zero sent");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (.*);
